FILE: rtl/ctcg_pkg.sv
// ----------------------------------------------------------------------------
// ctcg_pkg
// Shared types, codes and UTF-8 encoding helpers for the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcg_pkg;

	// result kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_CONF = 1'b1;

	// code point range limits per encoded length
	localparam logic [20:0] CP_MAX_1 = 21'h00007F;
	localparam logic [20:0] CP_MAX_2 = 21'h0007FF;
	localparam logic [20:0] CP_MAX_3 = 21'h00FFFF;
	localparam logic [20:0] CP_MAX_4 = 21'h10FFFF;

	// lead and continuation byte marks
	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] CONT   = 8'h80;

	// payload masks
	localparam logic [7:0] MASK_CONT = 8'h3F;
	localparam logic [7:0] MASK_L2   = 8'h1F;
	localparam logic [7:0] MASK_L3   = 8'h0F;
	localparam logic [7:0] MASK_L4   = 8'h07;

	// status from the iterative divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// number of bytes for a code point, zero when out of range
	function automatic logic [2:0] utf8_len(input logic [20:0] c);
		logic [2:0] n;
		if (c <= CP_MAX_1) begin
			n = 3'd1;
		end else if (c <= CP_MAX_2) begin
			n = 3'd2;
		end else if (c <= CP_MAX_3) begin
			n = 3'd3;
		end else if (c <= CP_MAX_4) begin
			n = 3'd4;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

	// continuation byte holding six payload bits
	function automatic logic [7:0] utf8_cont(input logic [5:0] bits);
		return CONT | ({2'b00, bits} & MASK_CONT);
	endfunction

	// byte number idx of the encoding of c with length n
	function automatic logic [7:0] utf8_byte(input logic [20:0] c, input logic [2:0] n,
		input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (n)
			3'd1: begin
				b = c[7:0];
			end
			3'd2: begin
				unique case (idx)
					2'd0:    b = LEAD_2 | ({3'b000, c[10:6]} & MASK_L2);
					default: b = utf8_cont(c[5:0]);
				endcase
			end
			3'd3: begin
				unique case (idx)
					2'd0:    b = LEAD_3 | ({4'b0000, c[15:12]} & MASK_L3);
					2'd1:    b = utf8_cont(c[11:6]);
					default: b = utf8_cont(c[5:0]);
				endcase
			end
			3'd4: begin
				unique case (idx)
					2'd0: b = LEAD_4 | ({5'b00000, c[20:18]} & MASK_L4);
					2'd1: b = utf8_cont(c[17:12]);
					2'd2: b = utf8_cont(c[11:6]);
					2'd3: b = utf8_cont(c[5:0]);
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/ctcg_div.sv
// ----------------------------------------------------------------------------
// ctcg_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctcg_div #(
	parameter int SW = 25,
	parameter int CW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SW-1:0]         dividend,
	input  logic [CW-1:0]         divisor,
	output logic [SW-1:0]         quotient,
	output ctcg_pkg::div_stat_t   stat
);
	import ctcg_pkg::*;

	localparam int SCW = (SW > 1) ? $clog2(SW) : 1;

	logic            busy_q;
	logic [SCW-1:0]  step_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   dsr_q;
	logic [SW-1:0]   quo_q;
	logic [CW:0]     trial;
	logic            ge;
	logic [CW:0]     rem_n;
	logic            done;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[SW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign rem_n = ge ? (trial - {1'b0, dsr_q}) : trial;
	assign done  = busy_q && (step_q == SCW'(SW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SCW'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_n[CW-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done;

	a_start_busy : assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");
	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		(done && !start) |=> !busy_q)
		else $error("divider still busy after done");
	a_run_on : assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !done) |=> busy_q)
		else $error("divider stopped early");

endmodule

FILE: rtl/ctc_greedy_utf8_decoder.sv
// ----------------------------------------------------------------------------
// ctc_greedy_utf8_decoder
// CTC greedy collapse of recognizer steps into UTF-8 bytes plus line confidence.
// ----------------------------------------------------------------------------
// a step is taken while idle, then its n bytes (0..4) leave one per cycle while the output is free
// a new step is taken only once the single byte sequencer is back in idle
// line end: the sequencer starts the radix-2 divider, waits for it, then loads confidence
// reset: arst_n clears sequencer, output valid and line state; no clearing pass
module ctc_greedy_utf8_decoder #(
	parameter int MAX_STEPS      = 512,
	parameter int PROB_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// step request
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [21:0]         code_point,
	input  logic [PROB_FRAC_BITS-1:0]  step_prob,
	input  logic                       seq_last,
	// result request
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       kind,
	output logic [7:0]                 utf8_byte,
	output logic                       char_end,
	output logic [PROB_FRAC_BITS-1:0]  confidence
);
	import ctcg_pkg::*;

	// count and sum widths follow the line length bound
	localparam int LW = $clog2(MAX_STEPS);
	localparam int CW = LW + 1;
	localparam int SW = PROB_FRAC_BITS + LW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_CONF
	} state_t;

	state_t                     state_q;

	// line state
	logic [20:0]                prev_code_q;
	logic                       prev_blank_q;
	logic [SW-1:0]              sum_q;
	logic [CW-1:0]              cnt_q;

	// current step being emitted
	logic [20:0]                code_q;
	logic [2:0]                 len_q;
	logic [1:0]                 idx_q;
	logic                       last_q;

	// output register
	logic                       out_valid_q;
	logic                       kind_q;
	logic [7:0]                 byte_q;
	logic                       end_q;
	logic [PROB_FRAC_BITS-1:0]  conf_q;

	// step decode
	logic                       in_fire;
	logic                       blank;
	logic [20:0]                code;
	logic [2:0]                 len;
	logic                       do_emit;
	logic [SW:0]                sum_add;
	logic [SW-1:0]              sum_next;
	logic [CW-1:0]              cnt_next;
	logic                       load_en;
	logic                       out_load;
	logic                       idx_at_end;

	// divider link
	logic                       div_start;
	logic [CW-1:0]              divisor;
	logic [SW-1:0]              quotient;
	div_stat_t                  div_stat;
	logic [PROB_FRAC_BITS-1:0]  conf_sat;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// sign bit marks a blank step
	assign blank   = code_point[21];
	assign code    = code_point[20:0];
	assign len     = utf8_len(code);
	assign do_emit = (prev_blank_q || (code != prev_code_q)) && (len != 3'd0);

	// saturating accumulation
	assign sum_add  = {1'b0, sum_q} + {{(SW + 1 - PROB_FRAC_BITS){1'b0}}, step_prob};
	assign sum_next = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
	assign cnt_next = (cnt_q == {CW{1'b1}}) ? cnt_q : (cnt_q + CW'(1));

	// output register can take a new result
	assign load_en    = !out_valid_q || out_ready;
	assign out_load   = load_en && ((state_q == ST_EMIT) || (state_q == ST_CONF));
	assign idx_at_end = (idx_q == 2'(len_q - 3'd1));

	// empty line divides by one
	assign div_start = (state_q == ST_DIV_START);
	assign divisor   = (cnt_q == '0) ? CW'(1) : cnt_q;

	// quotient clamps to the largest probability
	generate
		if (SW > PROB_FRAC_BITS) begin : g_clamp
			assign conf_sat = (|quotient[SW-1:PROB_FRAC_BITS]) ? {PROB_FRAC_BITS{1'b1}}
				: quotient[PROB_FRAC_BITS-1:0];
		end else begin : g_noclamp
			assign conf_sat = quotient[PROB_FRAC_BITS-1:0];
		end
	endgenerate

	ctcg_div #(
		.SW (SW),
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (divisor),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// sequencer, line state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_code_q  <= '0;
			prev_blank_q <= 1'b1;
			sum_q        <= '0;
			cnt_q        <= '0;
			code_q       <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_BYTE;
			byte_q       <= '0;
			end_q        <= 1'b0;
			conf_q       <= '0;
		end else begin
			// new result loaded, or result taken and nothing new loaded
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						code_q <= code;
						len_q  <= len;
						idx_q  <= 2'd0;
						last_q <= seq_last;
						if (!blank) begin
							sum_q        <= sum_next;
							cnt_q        <= cnt_next;
							prev_code_q  <= code;
							prev_blank_q <= 1'b0;
						end else begin
							prev_blank_q <= 1'b1;
						end
						if (!blank && do_emit) begin
							state_q <= ST_EMIT;
						end else if (seq_last) begin
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_EMIT: begin
					// one byte per free output slot
					if (load_en) begin
						kind_q      <= KIND_BYTE;
						byte_q      <= ctcg_pkg::utf8_byte(code_q, len_q, idx_q);
						end_q       <= idx_at_end;
						conf_q      <= '0;
						idx_q       <= idx_q + 2'd1;
						if (idx_at_end) begin
							state_q <= last_q ? ST_DIV_START : ST_IDLE;
						end
					end
				end
				ST_DIV_START: begin
					// divider latches sum and count, line state clears
					prev_code_q  <= '0;
					prev_blank_q <= 1'b1;
					sum_q        <= '0;
					cnt_q        <= '0;
					state_q      <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_CONF;
					end
				end
				ST_CONF: begin
					if (load_en) begin
						kind_q      <= KIND_CONF;
						byte_q      <= 8'h00;
						end_q       <= 1'b0;
						conf_q      <= conf_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign utf8_byte  = byte_q;
	assign char_end   = end_q;
	assign confidence = conf_q;

	a_last_leaves_idle : assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && seq_last) |=> (state_q != ST_IDLE))
		else $error("line end step did not start confidence");
	a_line_cleared : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_START) |=> (cnt_q == '0 && sum_q == '0 && prev_blank_q))
		else $error("line state not cleared");
	a_idx_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ({1'b0, idx_q} < len_q))
		else $error("byte index past encoded length");
	a_done_when_waiting : assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside wait");

endmodule

FILE: sim/ctcg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcg_checker
// Watches both requests of the CTC greedy decoder, predicts the byte and
// confidence results of every accepted step and compares them in order.
// ----------------------------------------------------------------------------
module ctcg_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [21:0] code_point,
	input  logic [15:0]        step_prob,
	input  logic               seq_last,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               kind,
	input  logic [7:0]         utf8_byte,
	input  logic               char_end,
	input  logic [15:0]        confidence,
	output int                 mismatch_cnt,
	output int                 owed_cnt
);
	import ctcg_pkg::*;

	localparam logic [24:0] SUM_FULL  = 25'h1FF_FFFF;
	localparam logic [15:0] MEAN_FULL = 16'hFFFF;

	typedef struct packed {
		logic        kind;
		logic [7:0]  octet;
		logic        last_octet;
		logic [15:0] conf;
	} line_out_t;

	line_out_t   owed_q[$];
	logic [20:0] last_code;
	logic        last_was_blank;
	logic [24:0] conf_sum;
	logic [9:0]  conf_cnt;
	int          fails;

	task automatic clear_line();
		last_code      = '0;
		last_was_blank = 1'b1;
		conf_sum       = '0;
		conf_cnt       = '0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fails++;
		$display("%0t mismatch in %s: got %h, want %h", $time, what, got, want);
	endtask

	// greedy collapse of one step, queues its bytes and any line confidence
	task automatic decode_step(input logic [21:0] cp, input logic [15:0] prob,
		input logic lst);
		logic [20:0] c;
		logic [7:0]  enc [4];
		logic [25:0] s;
		logic [9:0]  div;
		logic [24:0] quo;
		int          len;
		c   = cp[20:0];
		len = 0;
		if (!cp[21]) begin
			if (last_was_blank || c != last_code) begin
				if (c <= CP_MAX_1) begin
					enc[0] = {1'b0, c[6:0]};
					len    = 1;
				end else if (c <= CP_MAX_2) begin
					enc[0] = LEAD_2 | {3'b000, c[10:6]};
					enc[1] = CONT | {2'b00, c[5:0]};
					len    = 2;
				end else if (c <= CP_MAX_3) begin
					enc[0] = LEAD_3 | {4'b0000, c[15:12]};
					enc[1] = CONT | {2'b00, c[11:6]};
					enc[2] = CONT | {2'b00, c[5:0]};
					len    = 3;
				end else if (c <= CP_MAX_4) begin
					enc[0] = LEAD_4 | {5'b00000, c[20:18]};
					enc[1] = CONT | {2'b00, c[17:12]};
					enc[2] = CONT | {2'b00, c[11:6]};
					enc[3] = CONT | {2'b00, c[5:0]};
					len    = 4;
				end
				for (int i = 0; i < len; i++) begin
					owed_q.push_back('{KIND_BYTE, enc[i], (i == len - 1), 16'h0000});
				end
			end
			s        = {1'b0, conf_sum} + {10'd0, prob};
			conf_sum = (s > {1'b0, SUM_FULL}) ? SUM_FULL : s[24:0];
			if (conf_cnt != '1) begin
				conf_cnt = conf_cnt + 10'd1;
			end
			last_code      = c;
			last_was_blank = 1'b0;
		end else begin
			last_was_blank = 1'b1;
		end
		if (lst) begin
			div = (conf_cnt == '0) ? 10'd1 : conf_cnt;
			quo = conf_sum / div;
			owed_q.push_back('{KIND_CONF, 8'h00, 1'b0,
				(quo > {9'd0, MEAN_FULL}) ? MEAN_FULL : quo[15:0]});
			clear_line();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_out_t want;
		if (!arst_n) begin
			clear_line();
			owed_q.delete();
			fails = 0;
			mismatch_cnt <= 0;
			owed_cnt     <= 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_step(code_point, step_prob, seq_last);
			end
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					report_mismatch("unexpected result", {31'd0, kind}, 32'd0);
				end else begin
					want = owed_q.pop_front();
					if (kind !== want.kind) begin
						report_mismatch("kind", {31'd0, kind}, {31'd0, want.kind});
					end
					if (utf8_byte !== want.octet) begin
						report_mismatch("utf8_byte", {24'd0, utf8_byte}, {24'd0, want.octet});
					end
					if (char_end !== want.last_octet) begin
						report_mismatch("char_end", {31'd0, char_end}, {31'd0, want.last_octet});
					end
					if (confidence !== want.conf) begin
						report_mismatch("confidence", {16'd0, confidence}, {16'd0, want.conf});
					end
				end
			end
			mismatch_cnt <= fails;
			owed_cnt     <= owed_q.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives recognizer steps into the CTC greedy decoder: a directed pass over
// the UTF-8 length boundaries, blanks, repeats, out-of-range codes and one
// long line, then random text lines under random idling on both sides. The
// checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;
	import ctcg_pkg::*;

	localparam int STALL_LIMIT  = 2000;  // cycles with no accepted request
	localparam int TAIL_CYCLES  = 40;    // quiet tail after the final drain, with margin
	localparam int RAND_STEPS   = 240;
	localparam int LONG_LINE    = 100;   // one long directed line of a single repeated character
	localparam int CALM_FIRST   = 150;   // idling stops once this many random steps are sent
	localparam int CALM_LAST    = 230;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [21:0] code_point;
	logic [15:0]        step_prob;
	logic               seq_last;
	logic               out_valid;
	logic               out_ready;
	logic               kind;
	logic [7:0]         utf8_byte;
	logic               char_end;
	logic [15:0]        confidence;
	int                 mismatch_cnt;
	int                 owed_cnt;
	logic               steady;      // high while neither side idles
	int                 stall_cyc;

	ctc_greedy_utf8_decoder i_dut (.*);

	ctcg_checker i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver side: drops ready at random, with a chance of 37 in a hundred, unless steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 37);
		end
	end

	// watchdog: a run that stops moving is a failure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cyc <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cyc <= 0;
			end else begin
				stall_cyc <= stall_cyc + 1;
			end
			if (stall_cyc >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// one step request, with a random gap in front of it unless steady
	task automatic send_step(input logic signed [21:0] cp, input logic [15:0] prob,
		input logic lst);
		if (!steady) begin
			while ($urandom_range(99) < 37) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		code_point <= cp;
		step_prob  <= prob;
		seq_last   <= lst;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// sender holds off until every owed result has come back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_cnt != 0) begin
			@(posedge clk);
		end
	endtask

	// mostly well-formed codes of every length, some blanks, repeats and noise
	function automatic logic signed [21:0] pick_code(input logic signed [21:0] prev_cp);
		int r;
		r = $urandom_range(99);
		if (r < 4) begin
			return -22'sd1;
		end else if (r < 14) begin
			return {1'b1, 21'($urandom)};
		end else if (r < 32) begin
			return prev_cp;
		end else if (r < 37) begin
			return 22'($urandom);
		end
		case ($urandom_range(4))
			0:       return 22'($urandom_range(CP_MAX_1));
			1:       return 22'($urandom_range(CP_MAX_2, CP_MAX_1 + 1));
			2:       return 22'($urandom_range(CP_MAX_3, CP_MAX_2 + 1));
			3:       return 22'($urandom_range(CP_MAX_4, CP_MAX_3 + 1));
			default: return 22'($urandom_range(21'h1F_FFFF, CP_MAX_4 + 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_prob();
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			return 16'h0000;
		end else if (r < 20) begin
			return 16'hFFFF;
		end
		return 16'($urandom);
	endfunction

	initial begin
		int                 sent;
		int                 line_len;
		logic signed [21:0] cp;
		logic signed [21:0] prev_nb;
		// every input known from time zero, with reset asserted first
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		code_point <= '0;
		step_prob  <= '0;
		seq_last   <= 1'b0;
		steady     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// line of blanks only: confidence must come out zero
		send_step(-22'sd1, 16'hFFFF, 1'b1);
		// collapse of a repeat, re-emit after the most negative blank
		send_step(22'sh000000, 16'h0000, 1'b0);
		send_step(22'sh000000, 16'hFFFF, 1'b0);
		send_step(22'sh200000, 16'hFFFF, 1'b0);
		send_step(22'sh000000, 16'h1234, 1'b0);
		send_step(22'sh00007F, 16'h8000, 1'b1);
		// both sides of every UTF-8 length boundary
		send_step(22'sh000080, 16'hFFFF, 1'b0);
		send_step(22'sh0007FF, 16'h0001, 1'b0);
		send_step(22'sh000800, 16'hFFFF, 1'b0);
		send_step(22'sh00FFFF, 16'hFFFF, 1'b0);
		send_step(22'sh010000, 16'h0000, 1'b0);
		send_step(22'sh10FFFF, 16'hFFFF, 1'b1);
		// out-of-range codes emit nothing but still count and still collapse
		send_step(22'sh110000, 16'hFFFF, 1'b0);
		send_step(22'sh110000, 16'hFFFF, 1'b0);
		send_step(22'sh000041, 16'h0000, 1'b0);
		send_step(22'sh1FFFFF, 16'hFFFF, 1'b1);
		send_step(22'sh1FFFFF, 16'hFFFF, 1'b1);
		// alternating payload bits in two four-byte characters
		send_step(22'sh0AAAAA, 16'hAAAA, 1'b0);
		send_step(22'sh055555, 16'h5555, 1'b1);
		hold_until_drained();

		// one long line of a single repeated character at full probability
		for (int i = 0; i < LONG_LINE; i++) begin
			send_step(22'sh004E2D, 16'hFFFF, (i == LONG_LINE - 1));
		end
		hold_until_drained();

		// random text lines, now and then a long one, now and then a full drain
		sent    = 0;
		prev_nb = 22'sh000041;
		while (sent < RAND_STEPS) begin
			steady   <= (sent >= CALM_FIRST) && (sent < CALM_LAST);
			line_len = ($urandom_range(99) < 6) ? $urandom_range(120, 40)
				: $urandom_range(12, 1);
			for (int i = 0; i < line_len; i++) begin
				cp = pick_code(prev_nb);
				if (!cp[21]) begin
					prev_nb = cp;
				end
				send_step(cp, pick_prob(), (i == line_len - 1));
			end
			sent += line_len;
			if ($urandom_range(11) == 0) begin
				hold_until_drained();
			end
		end

		// wind down: every owed result back, then a short quiet tail
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/ctcg_pkg.sv
rtl/ctcg_div.sv
rtl/ctc_greedy_utf8_decoder.sv
sim/ctcg_checker.sv
sim/tb.sv
